// File: rtl/core/ansi_escape_sequence_parser_defines.svh
// Assertion macros shared by the escape sequence parser RTL.
// Depends on nothing; the including module supplies clock and reset.
`ifndef ANSI_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH
`define ANSI_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AESP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AESP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/aesp_pkg.sv
// Shared constants and types of the ANSI escape sequence parser.
// Depends on nothing; imported by aesp_step and the top level.
`default_nettype none

package aesp_pkg;

   localparam int MAX_SEQ_LEN    = 64;
   localparam int PARSE_BUF_SIZE = 8;

   localparam logic [6:0] SEQ_MAX = 7'(MAX_SEQ_LEN);
   localparam logic [6:0] BUF_LIM = 7'(PARSE_BUF_SIZE - 1);

   // parser modes
   localparam logic [3:0] MODE_IDLE    = 4'd0;
   localparam logic [3:0] MODE_ESC     = 4'd1;
   localparam logic [3:0] MODE_CSI     = 4'd2;
   localparam logic [3:0] MODE_OSC     = 4'd3;
   localparam logic [3:0] MODE_DCS     = 4'd4;
   localparam logic [3:0] MODE_PM      = 4'd5;
   localparam logic [3:0] MODE_APC     = 4'd6;
   localparam logic [3:0] MODE_SS3     = 4'd7;
   localparam logic [3:0] MODE_WAIT_ST = 4'd8;

   // result codes
   localparam logic [3:0] RC_NONE   = 4'd0;
   localparam logic [3:0] RC_PASS   = 4'd1;
   localparam logic [3:0] RC_UP     = 4'd2;
   localparam logic [3:0] RC_DOWN   = 4'd3;
   localparam logic [3:0] RC_RIGHT  = 4'd4;
   localparam logic [3:0] RC_LEFT   = 4'd5;
   localparam logic [3:0] RC_HOME   = 4'd6;
   localparam logic [3:0] RC_END    = 4'd7;
   localparam logic [3:0] RC_DELETE = 4'd8;
   localparam logic [3:0] RC_RESET  = 4'd9;

   // byte codes
   localparam logic [7:0] BYTE_BEL   = 8'h07;
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_BSL   = 8'h5C;
   localparam logic [7:0] BYTE_TILDE = 8'h7E;
   localparam logic [7:0] BYTE_LBRK  = 8'h5B;
   localparam logic [7:0] BYTE_RBRK  = 8'h5D;
   localparam logic [7:0] BYTE_P     = 8'h50;
   localparam logic [7:0] BYTE_CARET = 8'h5E;
   localparam logic [7:0] BYTE_USCR  = 8'h5F;
   localparam logic [7:0] BYTE_O     = 8'h4F;
   localparam logic [7:0] BYTE_A     = 8'h41;
   localparam logic [7:0] BYTE_B     = 8'h42;
   localparam logic [7:0] BYTE_C     = 8'h43;
   localparam logic [7:0] BYTE_D     = 8'h44;
   localparam logic [7:0] BYTE_F     = 8'h46;
   localparam logic [7:0] BYTE_H     = 8'h48;
   localparam logic [7:0] BYTE_1     = 8'h31;
   localparam logic [7:0] BYTE_3     = 8'h33;
   localparam logic [7:0] BYTE_4     = 8'h34;

   typedef struct packed {
      logic [3:0] parser_mode;
      logic [6:0] seq_count;
      logic [7:0] first_stored;
      logic [7:0] second_stored;
   } aesp_state_type;

   typedef struct packed {
      logic [3:0] result_code;
      logic [7:0] char_out;
   } aesp_result_type;

endpackage

`default_nettype wire

// File: rtl/core/aesp_step.sv
// Next-state and result logic of the escape sequence parser, one byte per pass.
// Depends on aesp_pkg.
`default_nettype none

module aesp_step (
   input  wire aesp_pkg::aesp_state_type  state_cur,
   input  wire logic [7:0]                byte_cur,
   output aesp_pkg::aesp_state_type       state_nxt,
   output aesp_pkg::aesp_result_type      result
);
   import aesp_pkg::*;

   logic [6:0] cnt_inc;
   logic       is_final;
   logic       is_middle;
   logic       is_param;
   logic [7:0] first_nx;
   logic [7:0] second_nx;
   logic [3:0] decode_code;

   assign cnt_inc   = state_cur.seq_count + 7'd1;
   assign is_final  = byte_cur inside {[8'h40:8'h7E]};
   assign is_middle = byte_cur inside {[8'h20:8'h2F]};
   assign is_param  = byte_cur inside {[8'h30:8'h39], 8'h3B, 8'h3C, 8'h3E, 8'h3F};

   // CSI byte store: the first two bytes of the body land in the two slots
   always_comb begin
      first_nx  = state_cur.first_stored;
      second_nx = state_cur.second_stored;
      if (state_cur.seq_count < BUF_LIM) begin
         if (state_cur.seq_count == 7'd0) begin
            first_nx = byte_cur;
         end else if (state_cur.seq_count == 7'd1) begin
            second_nx = byte_cur;
         end
      end
   end

   // key decode on the post-store count and slots
   always_comb begin
      decode_code = RC_NONE;
      if (cnt_inc == 7'd2 && second_nx == BYTE_TILDE) begin
         case (first_nx)
            BYTE_1:  decode_code = RC_HOME;
            BYTE_3:  decode_code = RC_DELETE;
            BYTE_4:  decode_code = RC_END;
            default: decode_code = RC_NONE;
         endcase
      end else if (cnt_inc == 7'd1) begin
         case (first_nx)
            BYTE_A:  decode_code = RC_UP;
            BYTE_B:  decode_code = RC_DOWN;
            BYTE_C:  decode_code = RC_RIGHT;
            BYTE_D:  decode_code = RC_LEFT;
            BYTE_F:  decode_code = RC_END;
            BYTE_H:  decode_code = RC_HOME;
            default: decode_code = RC_NONE;
         endcase
      end
   end

   always_comb begin
      state_nxt          = state_cur;
      result.result_code = RC_NONE;
      result.char_out    = 8'd0;
      case (state_cur.parser_mode)
         MODE_ESC: begin
            case (byte_cur)
               BYTE_LBRK:  state_nxt.parser_mode = MODE_CSI;
               BYTE_RBRK:  state_nxt.parser_mode = MODE_OSC;
               BYTE_P:     state_nxt.parser_mode = MODE_DCS;
               BYTE_CARET: state_nxt.parser_mode = MODE_PM;
               BYTE_USCR:  state_nxt.parser_mode = MODE_APC;
               BYTE_O:     state_nxt.parser_mode = MODE_SS3;
               default:    state_nxt.parser_mode = MODE_IDLE;
            endcase
         end
         MODE_OSC, MODE_DCS, MODE_PM, MODE_APC: begin
            if (byte_cur == BYTE_BEL) begin
               state_nxt.parser_mode = MODE_IDLE;
            end else if (byte_cur == BYTE_ESC) begin
               state_nxt.parser_mode = MODE_WAIT_ST;
            end else begin
               state_nxt.seq_count = cnt_inc;
               if (cnt_inc >= SEQ_MAX) begin
                  state_nxt.parser_mode = MODE_IDLE;
                  result.result_code    = RC_RESET;
               end
            end
         end
         MODE_SS3: begin
            state_nxt.parser_mode = MODE_IDLE;
            result.result_code    = is_final ? RC_NONE : RC_RESET;
         end
         MODE_WAIT_ST: begin
            state_nxt.parser_mode = MODE_IDLE;
            result.result_code    = (byte_cur == BYTE_BSL) ? RC_NONE : RC_RESET;
         end
         MODE_CSI: begin
            if (is_final) begin
               state_nxt.parser_mode   = MODE_IDLE;
               state_nxt.seq_count     = cnt_inc;
               state_nxt.first_stored  = first_nx;
               state_nxt.second_stored = second_nx;
               result.result_code      = (cnt_inc >= BUF_LIM) ? RC_NONE : decode_code;
            end else if (!is_middle && !is_param) begin
               state_nxt.parser_mode = MODE_IDLE;
               result.result_code    = RC_RESET;
            end else begin
               state_nxt.seq_count     = cnt_inc;
               state_nxt.first_stored  = first_nx;
               state_nxt.second_stored = second_nx;
               if (cnt_inc >= SEQ_MAX) begin
                  state_nxt.parser_mode = MODE_IDLE;
                  result.result_code    = RC_RESET;
               end
            end
         end
         default: begin
            // idle, and the unused codes that act as idle
            if (byte_cur == BYTE_ESC) begin
               state_nxt.parser_mode = MODE_ESC;
               state_nxt.seq_count   = 7'd0;
            end else begin
               state_nxt.parser_mode = MODE_IDLE;
               result.result_code    = RC_PASS;
               result.char_out       = byte_cur;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/ansi_escape_sequence_parser.sv
// Top level of the ANSI escape sequence parser: input register, state, result register.
// Depends on aesp_pkg, aesp_step and ansi_escape_sequence_parser_defines.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   req_    | in        | req_valid/req_stall| req_byte_in[7:0]
//   rsp_    | out       | rsp_valid/rsp_stall| rsp_result_code[3:0], rsp_char_out[7:0]
//
// One beat in and one beat out per cycle while rsp_stall is low; a byte passes
// through the input register, then one pass of the step logic into the result register.
// The parser state updates only when a byte moves into the result register.
// Synchronous reset returns the parser to idle with a zero count, clears the
// two stored CSI bytes and empties both registers.
// A stalled result holds; req_stall rises only when the input register is full
// and the result register cannot drain in the same cycle.
`default_nettype none
`include "ansi_escape_sequence_parser_defines.svh"

module ansi_escape_sequence_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_byte_in,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [3:0] rsp_result_code,
   output      logic [7:0] rsp_char_out
);
   import aesp_pkg::*;

   // input register
   logic       in_vld_ff;
   logic       in_vld_in;
   logic [7:0] in_byte_ff;

   // parser state
   aesp_state_type state_ff;
   aesp_state_type state_in;

   // result register
   logic            rsp_vld_ff;
   logic            rsp_vld_in;
   aesp_result_type rsp_ff;
   aesp_result_type step_result;

   logic out_free;
   logic advance;
   logic in_load;

   // the result slot can take a new beat when empty or being drained now
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   aesp_step u_step (
      .state_cur (state_ff),
      .byte_cur  (in_byte_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (in_load) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (out_free) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control state: valid flags and the whole parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff              <= 1'b0;
         rsp_vld_ff             <= 1'b0;
         state_ff.parser_mode   <= MODE_IDLE;
         state_ff.seq_count     <= 7'd0;
         state_ff.first_stored  <= 8'd0;
         state_ff.second_stored <= 8'd0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload: input byte and result
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_byte_in;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_result_code = rsp_ff.result_code;
   assign rsp_char_out    = rsp_ff.char_out;

   `AESP_ASSERT_IMP(a_char_only_on_pass, clock, reset, rsp_vld_ff && rsp_ff.result_code != RC_PASS, rsp_ff.char_out == 8'd0, "char_out set without passthrough")
   `AESP_ASSERT_IMP(a_code_range, clock, reset, rsp_vld_ff, rsp_ff.result_code <= RC_RESET, "result code out of range")
   `AESP_ASSERT_NXT(a_advance_fills, clock, reset, advance, rsp_vld_ff, "advanced beat missing from result register")
   `AESP_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, state_ff.seq_count <= SEQ_MAX, "sequence count past its limit")
   `AESP_ASSERT_IMP(a_mode_known, clock, reset, 1'b1, state_ff.parser_mode <= MODE_WAIT_ST, "parser mode in unused code")

endmodule

`default_nettype wire

// File: tb/ansi_escape_sequence_parser_tb.sv
// Self-checking testbench of the ANSI escape sequence parser: directed byte runs, then
// random terminal traffic with idle and stall patterns. Depends on aesp_pkg and the RTL.
`timescale 1ns / 1ps

module ansi_escape_sequence_parser_tb;
   import aesp_pkg::*;

   // byte classes of the CSI body and final
   localparam logic [7:0] MID_LO        = 8'h20;
   localparam logic [7:0] MID_HI        = 8'h2F;
   localparam logic [7:0] DIGIT_0       = 8'h30;
   localparam logic [7:0] DIGIT_9       = 8'h39;
   localparam logic [7:0] PARAM_SEMI    = 8'h3B;
   localparam logic [7:0] PARAM_LESS    = 8'h3C;
   localparam logic [7:0] PARAM_GREATER = 8'h3E;
   localparam logic [7:0] PARAM_QUEST   = 8'h3F;
   localparam logic [7:0] FINAL_LO      = 8'h40;
   localparam logic [7:0] FINAL_HI      = 8'h7E;

   localparam int HOLD_CYCLES = 60;     // long receiver hold-off
   localparam int MAX_REPORTS = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_result_code;
   logic [7:0] rsp_char_out;

   ansi_escape_sequence_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_in    (req_byte_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_code(rsp_result_code),
      .rsp_char_out   (rsp_char_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Parser state as the scoreboard sees it; the stored bytes start at zero, which is
   // never observed because a decode only reads bytes of the same sequence.
   logic [3:0] parse_mode   = MODE_IDLE;
   logic [6:0] parse_count  = 7'd0;
   logic [7:0] csi_first    = 8'h00;
   logic [7:0] csi_second   = 8'h00;

   aesp_result_type awaited_results[$];

   int fail_count    = 0;
   int bytes_sent    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asks     = 0;
   int hold_taken    = 0;
   int hold_left     = 0;

   // Keep the first two CSI bytes while they fit the parse buffer, count every one.
   function automatic void csi_keep(input logic [7:0] c);
      if (parse_count < BUF_LIM) begin
         if (parse_count == 7'd0) csi_first = c;
         else if (parse_count == 7'd1) csi_second = c;
      end
      parse_count = parse_count + 7'd1;
   endfunction

   function automatic bit is_final(input logic [7:0] c);
      return c >= FINAL_LO && c <= FINAL_HI;
   endfunction

   // Advance the parser by one byte and return the result beat it must produce.
   function automatic aesp_result_type parse_byte(input logic [7:0] c);
      aesp_result_type r;
      bit body_ok;
      r.result_code = RC_NONE;
      r.char_out    = 8'h00;
      body_ok = (c >= MID_LO && c <= MID_HI) || (c >= DIGIT_0 && c <= DIGIT_9) ||
                c == PARAM_SEMI || c == PARAM_LESS || c == PARAM_GREATER ||
                c == PARAM_QUEST;
      case (parse_mode)
         MODE_ESC: begin
            case (c)
               BYTE_LBRK:  parse_mode = MODE_CSI;
               BYTE_RBRK:  parse_mode = MODE_OSC;
               BYTE_P:     parse_mode = MODE_DCS;
               BYTE_CARET: parse_mode = MODE_PM;
               BYTE_USCR:  parse_mode = MODE_APC;
               BYTE_O:     parse_mode = MODE_SS3;
               default:    parse_mode = MODE_IDLE;
            endcase
         end
         MODE_OSC, MODE_DCS, MODE_PM, MODE_APC: begin
            if (c == BYTE_BEL) begin
               parse_mode = MODE_IDLE;
            end else if (c == BYTE_ESC) begin
               parse_mode = MODE_WAIT_ST;
            end else begin
               parse_count = parse_count + 7'd1;
               if (parse_count >= SEQ_MAX) begin
                  parse_mode    = MODE_IDLE;
                  r.result_code = RC_RESET;
               end
            end
         end
         MODE_SS3: begin
            parse_mode = MODE_IDLE;
            if (!is_final(c)) r.result_code = RC_RESET;
         end
         MODE_WAIT_ST: begin
            parse_mode = MODE_IDLE;
            if (c != BYTE_BSL) r.result_code = RC_RESET;
         end
         MODE_CSI: begin
            if (is_final(c)) begin
               parse_mode = MODE_IDLE;
               csi_keep(c);
               if (parse_count >= BUF_LIM) begin
                  r.result_code = RC_NONE;
               end else if (parse_count == 7'd2 && csi_second == BYTE_TILDE) begin
                  case (csi_first)
                     BYTE_1:  r.result_code = RC_HOME;
                     BYTE_3:  r.result_code = RC_DELETE;
                     BYTE_4:  r.result_code = RC_END;
                     default: r.result_code = RC_NONE;
                  endcase
               end else if (parse_count == 7'd1) begin
                  case (csi_first)
                     BYTE_A:  r.result_code = RC_UP;
                     BYTE_B:  r.result_code = RC_DOWN;
                     BYTE_C:  r.result_code = RC_RIGHT;
                     BYTE_D:  r.result_code = RC_LEFT;
                     BYTE_F:  r.result_code = RC_END;
                     BYTE_H:  r.result_code = RC_HOME;
                     default: r.result_code = RC_NONE;
                  endcase
               end
            end else if (!body_ok) begin
               parse_mode    = MODE_IDLE;
               r.result_code = RC_RESET;
            end else begin
               csi_keep(c);
               if (parse_count >= SEQ_MAX) begin
                  parse_mode    = MODE_IDLE;
                  r.result_code = RC_RESET;
               end
            end
         end
         default: begin
            // idle, and the unused mode codes act the same
            if (c == BYTE_ESC) begin
               parse_mode  = MODE_ESC;
               parse_count = 7'd0;
            end else begin
               parse_mode    = MODE_IDLE;
               r.result_code = RC_PASS;
               r.char_out    = c;
            end
         end
      endcase
      return r;
   endfunction

   // Offer one byte, idling first at the current sender rate, and hold it until the
   // parser takes it. Valid stays high on return so back-to-back bytes need no gap.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      awaited_results.push_back(parse_byte(b));
      bytes_sent++;
   endtask

   // Drop valid and pause until every awaited result beat has come back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] csi_body_byte();
      int pick;
      pick = $urandom_range(0, 6);
      if (pick < 2) return 8'($urandom_range(MID_LO, MID_HI));
      if (pick < 4) return 8'($urandom_range(DIGIT_0, DIGIT_9));
      if (pick == 4) return PARAM_SEMI;
      if (pick == 5) return $urandom_range(0, 1) ? PARAM_LESS : PARAM_GREATER;
      return PARAM_QUEST;
   endfunction

   // Receiver: a requested hold-off is counted down here, otherwise stall at random.
   always @(posedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken = hold_asks;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Check each accepted result beat against the oldest awaited one.
   always @(posedge clock) begin
      aesp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected beat: code %0d char %02h", rsp_result_code,
                        rsp_char_out);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_result_code !== want.result_code || rsp_char_out !== want.char_out)
            begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: expected code %0d char %02h, got code %0d char %02h",
                           want.result_code, want.char_out, rsp_result_code,
                           rsp_char_out);
            end
         end
      end
   end

   // Extremes of the byte pass straight through while idle.
   task automatic test_passthrough();
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // One single-letter cursor key and two tilde keys.
   task automatic test_cursor_keys();
      send_byte(BYTE_ESC); send_byte(BYTE_LBRK); send_byte(BYTE_A);
      send_byte(BYTE_ESC); send_byte(BYTE_LBRK); send_byte(BYTE_3); send_byte(BYTE_TILDE);
      send_byte(BYTE_ESC); send_byte(BYTE_LBRK); send_byte(BYTE_4); send_byte(BYTE_TILDE);
   endtask

   // SS3 good and bad, string ends on BEL, on ESC backslash, and on a broken terminator,
   // then an illegal byte inside CSI.
   task automatic test_escape_modes();
      send_byte(BYTE_ESC); send_byte(BYTE_O); send_byte(BYTE_P);
      send_byte(BYTE_ESC); send_byte(BYTE_O); send_byte(BYTE_BEL);
      send_byte(BYTE_ESC); send_byte(BYTE_RBRK); send_byte(BYTE_A); send_byte(BYTE_BEL);
      send_byte(BYTE_ESC); send_byte(BYTE_P); send_byte(BYTE_ESC); send_byte(BYTE_BSL);
      send_byte(BYTE_ESC); send_byte(BYTE_USCR); send_byte(BYTE_ESC); send_byte(BYTE_A);
      send_byte(BYTE_ESC); send_byte(BYTE_LBRK); send_byte(BYTE_ESC);
   endtask

   // Hold the receiver off for a long stretch while bytes keep coming, so the parser
   // fills and stalls its input; then pause until everything has drained.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asks++;
      repeat (4) begin
         send_byte(BYTE_ESC); send_byte(BYTE_LBRK); send_byte(BYTE_1); send_byte(BYTE_TILDE);
         send_byte(8'($urandom_range(0, 255)));
      end
      wait_all_results();
   endtask

   // One random sequence: mostly well formed with random content, some broken, some noise.
   task automatic send_random_sequence();
      int pick;
      int len;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         len = $urandom_range(1, 4);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
         send_byte(BYTE_ESC);
         send_byte(BYTE_LBRK);
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 6))
               0: b = BYTE_A;
               1: b = BYTE_B;
               2: b = BYTE_C;
               3: b = BYTE_D;
               4: b = BYTE_F;
               5: b = BYTE_H;
               default: b = 8'($urandom_range(FINAL_LO, FINAL_HI));
            endcase
            send_byte(b);
         end else begin
            case ($urandom_range(0, 3))
               0: b = BYTE_1;
               1: b = BYTE_3;
               2: b = BYTE_4;
               default: b = csi_body_byte();
            endcase
            send_byte(b);
            send_byte($urandom_range(0, 7) != 0 ? BYTE_TILDE
                                                : 8'($urandom_range(FINAL_LO, FINAL_HI)));
         end
      end else if (pick < 60) begin
         // general CSI: random body length, mostly legal final
         send_byte(BYTE_ESC);
         send_byte(BYTE_LBRK);
         len = $urandom_range(0, 9);
         repeat (len) send_byte(csi_body_byte());
         send_byte($urandom_range(0, 9) != 0 ? 8'($urandom_range(FINAL_LO, FINAL_HI))
                                             : 8'($urandom_range(0, 255)));
      end else if (pick < 63) begin
         // CSI that runs into the length limit, sometimes with a final near it
         send_byte(BYTE_ESC);
         send_byte(BYTE_LBRK);
         len = $urandom_range(SEQ_MAX - 3, SEQ_MAX + 2);
         repeat (len) send_byte(csi_body_byte());
         if ($urandom_range(0, 1)) send_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
      end else if (pick < 80) begin
         // string sequence with a random introducer, body and terminator
         send_byte(BYTE_ESC);
         case ($urandom_range(0, 3))
            0: send_byte(BYTE_RBRK);
            1: send_byte(BYTE_P);
            2: send_byte(BYTE_CARET);
            default: send_byte(BYTE_USCR);
         endcase
         len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 12)
                                           : $urandom_range(SEQ_MAX - 4, SEQ_MAX + 2);
         repeat (len) begin
            b = 8'($urandom_range(0, 255));
            if ((b == BYTE_BEL || b == BYTE_ESC) && $urandom_range(0, 7) != 0)
               b = 8'($urandom_range(MID_LO, FINAL_HI));
            send_byte(b);
         end
         case ($urandom_range(0, 3))
            0: send_byte(BYTE_BEL);
            1: begin
               send_byte(BYTE_ESC);
               send_byte(BYTE_BSL);
            end
            2: begin
               send_byte(BYTE_ESC);
               send_byte(8'($urandom_range(0, 255)));
            end
            default: ;
         endcase
      end else if (pick < 90) begin
         send_byte(BYTE_ESC);
         send_byte(BYTE_O);
         send_byte($urandom_range(0, 1) ? 8'($urandom_range(FINAL_LO, FINAL_HI))
                                        : 8'($urandom_range(0, 255)));
      end else begin
         // noise: ESC followed by anything
         send_byte(BYTE_ESC);
         len = $urandom_range(1, 3);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_traffic(input int count, input int snd_pct,
                                      input int rcv_pct);
      int start;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      start = bytes_sent;
      while (bytes_sent - start < count) send_random_sequence();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_passthrough();
      test_cursor_keys();
      test_escape_modes();
      test_backpressure();
      test_random_traffic(400, 22, 64);
      test_random_traffic(400, 64, 22);
      test_random_traffic(400, 0, 0);
      wait_all_results();
      // allow the input and result registers to show any stray beat
      repeat (8) @(posedge clock);
      if (fail_count == 0 && awaited_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/aesp_pkg.sv
rtl/core/aesp_step.sv
rtl/core/ansi_escape_sequence_parser.sv
tb/ansi_escape_sequence_parser_tb.sv
